// ----- src/in_order_result_reorder_buffer_assert.svh -----
// assertion macros used by the top-level reorder buffer module
// no dependencies; included inside that module's body
`ifndef IN_ORDER_RESULT_REORDER_BUFFER_ASSERT_SVH
`define IN_ORDER_RESULT_REORDER_BUFFER_ASSERT_SVH

// consequent checked in the same cycle
`define ROR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define ROR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ror_pkg.sv -----
// types and constants of the in-order result reorder buffer
// no dependencies
package ror_pkg;

    localparam int TAG_BITS    = 8;
    localparam int VALUE_WIDTH = 32;
    localparam int DEF_DEPTH   = 16;
    localparam int Q_DEPTH     = 2;

    typedef enum logic [2:0] {
        K_GRANT    = 3'd0,
        K_RESULT   = 3'd1,
        K_FULL     = 3'd2,
        K_BUFFERED = 3'd3,
        K_BAD      = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        OP_GRANT,
        OP_FULL,
        OP_BAD,
        OP_BUFFER,
        OP_DRAIN
    } t_op;

    typedef struct packed {
        logic                   action;
        logic [TAG_BITS-1:0]    done_tag;
        logic [VALUE_WIDTH-1:0] result_value;
    } t_in;

    typedef struct packed {
        t_kind                  kind;
        logic [TAG_BITS-1:0]    seq_tag;
        logic [VALUE_WIDTH-1:0] out_value;
        logic                   last;
    } t_res;

    typedef struct packed {
        t_op                    op;
        logic [TAG_BITS-1:0]    tag;
        logic [VALUE_WIDTH-1:0] value;
    } t_cmd;

endpackage

// ----- src/in_order_result_reorder_buffer.sv -----
// Grant, refuse, bad-tag and buffered beats: the result is registered in the back part
// after the queue; busy drops as it shows, so no new beat is taken before that result.
// A completion that drains n results: each result passes through S_READ and S_EMIT, set
// by the registered read of the value RAM; busy stays high until the last result shows.
// Synchronous active-low reset clears tag counters, ready flags and the queue;
// the value RAM is not cleared and needs no clearing pass. Results cannot be stalled.
module in_order_result_reorder_buffer import ror_pkg::*; #(
    parameter int DEPTH = DEF_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_in,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);
    localparam int IW = $clog2(DEPTH);
    localparam int QW = IW + $bits(t_cmd);

    logic                q_push;
    logic                q_pop;
    logic                q_empty;
    logic                q_full;
    logic [QW-1:0]       q_wdata;
    logic [QW-1:0]       q_rdata;
    logic [TAG_BITS-1:0] emit;
    logic [IW-1:0]       head;
    logic [DEPTH-1:0]    ready;
    logic                back_busy;
    logic                accept;

    assign busy   = back_busy || !q_empty;
    assign accept = start && !busy && !q_full;

    ror_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .i_emit   (emit),
        .i_head   (head),
        .i_ready  (ready),
        .o_push   (q_push),
        .o_qdata  (q_wdata)
    );

    ror_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    ror_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!q_empty),
        .i_qdata   (q_rdata),
        .o_pop     (q_pop),
        .o_emit    (emit),
        .o_head    (head),
        .o_ready   (ready),
        .o_busy    (back_busy),
        .o_valid   (o_valid),
        .o_res     (o_res)
    );

`include "in_order_result_reorder_buffer_assert.svh"

    `ROR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy,
        "accepted beat left busy low")
    `ROR_ASSERT_NOW(a_mid_is_result, i_clk, i_rst_n, o_valid && !o_res.last,
        o_res.kind == K_RESULT, "non-final beat is not an in-order result")
    `ROR_ASSERT_NEXT(a_drain_goes_on, i_clk, i_rst_n, o_valid && !o_res.last,
        busy && !o_valid, "drain stopped after a non-final beat")
    `ROR_ASSERT_NOW(a_zero_value, i_clk, i_rst_n, o_valid && o_res.kind != K_RESULT,
        o_res.out_value == '0, "value set on a non-result beat")
endmodule

// ----- src/ror_ram.sv -----
// generic single-write, single-read RAM with registered read data
// no dependencies
module ror_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/ror_fifo.sv -----
// short command queue between the front and back parts
// no dependencies
module ror_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty,
    output logic             o_full
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ----- src/ror_front.sv -----
// front part: accepts a beat, classifies it and queues a command
// depends on ror_pkg; reads slot status owned by ror_back
module ror_front import ror_pkg::*; #(
    parameter int DEPTH = DEF_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  t_in                                 i_in,
    input  logic [TAG_BITS-1:0]                 i_emit,
    input  logic [$clog2(DEPTH)-1:0]            i_head,
    input  logic [DEPTH-1:0]                    i_ready,
    output logic                                o_push,
    output logic [$clog2(DEPTH)+$bits(t_cmd)-1:0] o_qdata
);
    localparam int IW    = $clog2(DEPTH);
    localparam int TMAX  = (1 << TAG_BITS) - 1;
    localparam int CAP   = (DEPTH < TMAX) ? DEPTH : TMAX;

    logic [TAG_BITS-1:0] r_issue;
    logic [TAG_BITS-1:0] outstanding;
    logic [TAG_BITS-1:0] offset;
    logic                in_range;
    logic                held;
    logic                full;
    logic [IW:0]         sum;
    logic [IW-1:0]       idx;
    t_cmd                cmd;

    assign outstanding = r_issue - i_emit;
    assign offset      = i_in.done_tag - i_emit;
    assign full        = (outstanding >= TAG_BITS'(CAP));
    assign in_range    = (offset < outstanding) && (offset < TAG_BITS'(DEPTH));
    assign sum         = {1'b0, i_head} + {1'b0, offset[IW-1:0]};
    assign idx         = (sum >= (IW + 1)'(DEPTH)) ? IW'(sum - (IW + 1)'(DEPTH)) : sum[IW-1:0];
    assign held        = in_range && i_ready[idx];

    always_comb begin
        cmd.value = i_in.result_value;
        if (!i_in.action) begin
            cmd.op  = full ? OP_FULL : OP_GRANT;
            cmd.tag = full ? '0 : r_issue;
        end else begin
            cmd.tag = i_in.done_tag;
            if (!in_range || held) begin
                cmd.op = OP_BAD;
            end else if (offset == '0) begin
                cmd.op = OP_DRAIN;
            end else begin
                cmd.op = OP_BUFFER;
            end
        end
    end

    assign o_push  = i_accept;
    assign o_qdata = {idx, cmd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= '0;
        end else if (i_accept && cmd.op == OP_GRANT) begin
            r_issue <= r_issue + 1'b1;
        end
    end
endmodule

// ----- src/ror_back.sv -----
// back part: executes queued commands, holds slot state and value RAM
// depends on ror_pkg and ror_ram
module ror_back import ror_pkg::*; #(
    parameter int DEPTH = DEF_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    input  logic [$clog2(DEPTH)+$bits(t_cmd)-1:0] i_qdata,
    output logic                                  o_pop,
    output logic [TAG_BITS-1:0]                   o_emit,
    output logic [$clog2(DEPTH)-1:0]              o_head,
    output logic [DEPTH-1:0]                      o_ready,
    output logic                                  o_busy,
    output logic                                  o_valid,
    output t_res                                  o_res
);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $bits(t_cmd);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [TAG_BITS-1:0]    r_emit;
    logic [IW-1:0]          r_head;
    logic [DEPTH-1:0]       r_ready;
    logic                   r_valid;
    t_res                   r_res;
    t_cmd                   q_cmd;
    logic [IW-1:0]          q_idx;
    logic [IW-1:0]          head_nx;
    logic                   we;
    logic [VALUE_WIDTH-1:0] rdata;

    assign q_cmd   = t_cmd'(i_qdata[CW-1:0]);
    assign q_idx   = i_qdata[CW+IW-1:CW];
    assign head_nx = (r_head == IW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign we      = o_pop && (q_cmd.op == OP_BUFFER || q_cmd.op == OP_DRAIN);

    ror_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (q_idx),
        .i_wdata (q_cmd.value),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_emit  <= '0;
            r_head  <= '0;
            r_ready <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_res.seq_tag   <= q_cmd.tag;
                        r_res.out_value <= '0;
                        r_res.last      <= 1'b1;
                        case (q_cmd.op)
                            OP_GRANT: begin
                                r_res.kind <= K_GRANT;
                                r_valid    <= 1'b1;
                            end
                            OP_FULL: begin
                                r_res.kind <= K_FULL;
                                r_valid    <= 1'b1;
                            end
                            OP_BUFFER: begin
                                r_ready[q_idx] <= 1'b1;
                                r_res.kind     <= K_BUFFERED;
                                r_valid        <= 1'b1;
                            end
                            OP_DRAIN: begin
                                r_ready[q_idx] <= 1'b1;
                                r_state        <= S_READ;
                            end
                            default: begin
                                r_res.kind <= K_BAD;
                                r_valid    <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_res.kind      <= K_RESULT;
                    r_res.seq_tag   <= r_emit;
                    r_res.out_value <= rdata;
                    r_res.last      <= !r_ready[head_nx];
                    r_valid         <= 1'b1;
                    r_ready[r_head] <= 1'b0;
                    r_emit          <= r_emit + 1'b1;
                    r_head          <= head_nx;
                    r_state         <= r_ready[head_nx] ? S_READ : S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_emit  = r_emit;
    assign o_head  = r_head;
    assign o_ready = r_ready;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

// ----- tb/tb.sv -----
// testbench for the in-order result reorder buffer: drives issue and completion beats
// and checks every result against a predictor held in a scoreboard class
// depends on ror_pkg and in_order_result_reorder_buffer
module tb;
    import ror_pkg::*;

    localparam int DEPTH          = DEF_DEPTH;
    localparam int TAG_SPAN       = (1 << TAG_BITS) - 1;
    localparam int CAP            = (DEPTH < TAG_SPAN) ? DEPTH : TAG_SPAN;
    localparam int N_ITEMS        = 330;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;

    class rob_scoreboard;
        logic [TAG_BITS-1:0]    issue_tag;
        logic [TAG_BITS-1:0]    emit_tag;
        logic                   slot_full [DEPTH];
        logic [VALUE_WIDTH-1:0] slot_val  [DEPTH];
        t_res                   due_results [$];
        int                     errors;

        function new();
            issue_tag = '0;
            emit_tag  = '0;
            errors    = 0;
            foreach (slot_full[k]) begin
                slot_full[k] = 1'b0;
                slot_val[k]  = '0;
            end
        endfunction

        function void add_due(t_kind kind, logic [TAG_BITS-1:0] tag,
                              logic [VALUE_WIDTH-1:0] value, logic last);
            t_res r;
            r.kind      = kind;
            r.seq_tag   = tag;
            r.out_value = value;
            r.last      = last;
            due_results.push_back(r);
        endfunction

        function void note_beat(t_in beat);
            logic [TAG_BITS-1:0] span;
            logic [TAG_BITS-1:0] offs;
            t_res                tail;
            span = issue_tag - emit_tag;
            if (!beat.action) begin
                if (span >= CAP) begin
                    add_due(K_FULL, '0, '0, 1'b1);
                end else begin
                    add_due(K_GRANT, issue_tag, '0, 1'b1);
                    issue_tag = issue_tag + 1'b1;
                end
                return;
            end
            offs = beat.done_tag - emit_tag;
            if (offs >= span || offs >= DEPTH || slot_full[offs]) begin
                add_due(K_BAD, beat.done_tag, '0, 1'b1);
                return;
            end
            slot_full[offs] = 1'b1;
            slot_val[offs]  = beat.result_value;
            if (!slot_full[0]) begin
                add_due(K_BUFFERED, beat.done_tag, '0, 1'b1);
                return;
            end
            while (slot_full[0]) begin
                add_due(K_RESULT, emit_tag, slot_val[0], 1'b0);
                emit_tag = emit_tag + 1'b1;
                for (int k = 0; k + 1 < DEPTH; k++) begin
                    slot_full[k] = slot_full[k + 1];
                    slot_val[k]  = slot_val[k + 1];
                end
                slot_full[DEPTH - 1] = 1'b0;
                slot_val[DEPTH - 1]  = '0;
            end
            tail = due_results.pop_back();
            tail.last = 1'b1;
            due_results.push_back(tail);
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (due_results.size() == 0) begin
                $display("%0t: result with none expected, expected nothing actual %p",
                         $time, got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind)
                report("kind", want.kind, got.kind);
            if (got.seq_tag !== want.seq_tag)
                report("seq_tag", want.seq_tag, got.seq_tag);
            if (got.out_value !== want.out_value)
                report("out_value", want.out_value, got.out_value);
            if (got.last !== want.last)
                report("last", want.last, got.last);
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_in  i_in    = '0;
    logic busy;
    logic o_valid;
    t_res o_res;

    rob_scoreboard sb;
    int            sent;
    bit            burst;
    int            idle_cycles;

    in_order_result_reorder_buffer #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_in    (i_in),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_res);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [VALUE_WIDTH-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in issue_beat();
        t_in beat;
        beat.action       = 1'b0;
        beat.done_tag     = TAG_BITS'($urandom);
        beat.result_value = $urandom;
        return beat;
    endfunction

    function automatic t_in done_beat(logic [TAG_BITS-1:0] tag, logic [VALUE_WIDTH-1:0] value);
        t_in beat;
        beat.action       = 1'b1;
        beat.done_tag     = tag;
        beat.result_value = value;
        return beat;
    endfunction

    task automatic send_beat(input t_in beat);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= beat;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_beat(beat);
        sent++;
    endtask

    task automatic send_noise();
        t_in beat;
        beat.action       = 1'($urandom_range(0, 1));
        beat.result_value = rand_value();
        if ($urandom_range(0, 1) == 0)
            beat.done_tag = TAG_BITS'(sb.emit_tag + $urandom_range(0, DEPTH + 1));
        else
            beat.done_tag = TAG_BITS'($urandom);
        send_beat(beat);
    endtask

    // issue tags, complete every open tag shuffled or reversed; or send noise only
    task automatic run_batch();
        int                  n_issue;
        int                  pick;
        bit                  reverse;
        logic [TAG_BITS-1:0] span;
        logic [TAG_BITS-1:0] open_tags [$];
        burst = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 9) < 2) begin
            repeat ($urandom_range(1, 6)) send_noise();
            return;
        end
        n_issue = ($urandom_range(0, 5) == 0) ? DEPTH + $urandom_range(0, 2)
                                              : $urandom_range(1, 8);
        reverse = ($urandom_range(0, 3) == 0);
        repeat (n_issue) send_beat(issue_beat());
        forever begin
            open_tags.delete();
            span = sb.issue_tag - sb.emit_tag;
            for (int k = 0; k < span; k++) begin
                if (!sb.slot_full[k])
                    open_tags.push_back(TAG_BITS'(sb.emit_tag + k));
            end
            if (open_tags.size() == 0)
                break;
            if ($urandom_range(0, 11) == 0)
                send_noise();
            pick = reverse ? open_tags.size() - 1 : $urandom_range(0, open_tags.size() - 1);
            send_beat(done_beat(open_tags[pick], rand_value()));
        end
    endtask

    initial begin
        sb    = new();
        sent  = 0;
        burst = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_beat(done_beat(8'd0, '1));
        repeat (DEPTH) send_beat(issue_beat());
        send_beat(issue_beat());
        send_beat(done_beat(8'hff, '0));
        send_beat(done_beat(8'd5, '1));
        send_beat(done_beat(8'd5, 32'h1234_5678));
        send_beat(done_beat(8'd0, '0));

        while (sent < N_ITEMS) run_batch();
        start <= 1'b0;

        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
